>>> src/bcc_pkg.sv
package bcc_pkg;

    localparam int POS_W           = 8;
    localparam int LAYER_W         = 8;
    localparam int CNT_W           = 6;
    localparam int SUM_W           = 11;
    localparam int IDX_W           = 6;
    localparam int MAX_EDGES_DEF   = 64;
    localparam int MAX_LAYER_NODES = 256;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    // edge traveling down the chain, collecting its own crossing counts
    typedef struct packed {
        logic             vld;
        logic             drop;   // store was full at entry, never stored
        logic             done;   // already parked in a cell
        logic             last;
        logic [POS_W-1:0] src;
        logic [POS_W-1:0] dst;
        logic             inn;
        logic [CNT_W-1:0] ii;
        logic [CNT_W-1:0] ir;
        logic [CNT_W-1:0] rr;
    } t_tok;

    // edge parked in a cell
    typedef struct packed {
        logic             vld;
        logic [POS_W-1:0] src;
        logic [POS_W-1:0] dst;
        logic             inn;
        logic [CNT_W-1:0] ii;
        logic [CNT_W-1:0] ir;
        logic [CNT_W-1:0] rr;
    } t_ent;

    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] v;
        v = p;
        if (32'(p) >= MAX_LAYER_NODES) begin
            v = POS_W'(MAX_LAYER_NODES - 1);
        end
        return v;
    endfunction

endpackage

>>> src/bcc_cell.sv
module bcc_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  bcc_pkg::t_tok i_tok,
    input  bcc_pkg::t_ent i_nxt,
    output bcc_pkg::t_tok o_tok,
    output bcc_pkg::t_ent o_ent
);

    bcc_pkg::t_tok r_tok;
    bcc_pkg::t_ent r_ent;
    bcc_pkg::t_ent n_ent;

    logic w_live;
    logic w_store;
    logic w_cross;
    logic w_c_ii;
    logic w_c_ir;
    logic w_c_rr;

    assign w_live  = r_tok.vld && !r_tok.done;
    assign w_store = w_live && !r_ent.vld;
    // strictly opposite order on both layers
    assign w_cross = w_live && r_ent.vld &&
                     (((r_tok.src < r_ent.src) && (r_tok.dst > r_ent.dst)) ||
                      ((r_tok.src > r_ent.src) && (r_tok.dst < r_ent.dst)));
    assign w_c_ii  = w_cross && r_tok.inn && r_ent.inn;
    assign w_c_ir  = w_cross && (r_tok.inn ^ r_ent.inn);
    assign w_c_rr  = w_cross && !r_tok.inn && !r_ent.inn;

    always_comb begin
        o_tok = r_tok;
        if (w_store) begin
            o_tok.done = 1'b1;
        end
        o_tok.ii = r_tok.ii + bcc_pkg::CNT_W'(w_c_ii);
        o_tok.ir = r_tok.ir + bcc_pkg::CNT_W'(w_c_ir);
        o_tok.rr = r_tok.rr + bcc_pkg::CNT_W'(w_c_rr);
    end

    always_comb begin
        n_ent = r_ent;
        if (i_shift) begin
            n_ent = i_nxt;
        end else if (w_store) begin
            n_ent.vld = 1'b1;
            n_ent.src = r_tok.src;
            n_ent.dst = r_tok.dst;
            n_ent.inn = r_tok.inn;
            n_ent.ii  = r_tok.ii;
            n_ent.ir  = r_tok.ir;
            n_ent.rr  = r_tok.rr;
        end else begin
            n_ent.ii = r_ent.ii + bcc_pkg::CNT_W'(w_c_ii);
            n_ent.ir = r_ent.ir + bcc_pkg::CNT_W'(w_c_ir);
            n_ent.rr = r_ent.rr + bcc_pkg::CNT_W'(w_c_rr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
            r_ent.vld <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_ent <= n_ent;
        end
    end

    assign o_ent = r_ent;

endmodule

>>> src/bilayer_crossing_counter_unit.sv
// Bilayer edge crossing counter. Each input item is one edge between two
// adjacent layers (source position, target position, inner-segment flag in
// tuser); tlast closes the layer pair. Edges are taken one per cycle while a
// run is open. Each item enters a row of MAX_EDGES cells and moves one cell
// per cycle, comparing itself with the edge parked in each cell, bumping both
// edges' counters on a crossing, and parking in the first empty cell. After
// the tlast item is taken the input stalls: that item must pass through every
// cell of the row, then one result per stored edge follows, one per cycle
// while the sink is ready, in arrival order. The row shifts toward the
// output as results leave, so it is empty again when the run ends; there is
// no clearing pass after reset. The length of the cell row sets the drain
// time. Edges past MAX_EDGES are dropped and flagged in every result of the
// run.
module bilayer_crossing_counter_unit #(
    parameter int MAX_EDGES = bcc_pkg::MAX_EDGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] layer_index, [15:8] from_pos, [23:16] to_pos
    input  logic [bcc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] is_inner
    input  logic                          s_axis_tuser,
    // last_edge
    input  logic                          s_axis_tlast,
    // result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] layer_out, [13:8] edge_index, [19:14] edge_ii, [25:20] edge_ir,
    // [31:26] edge_rr, [42:32] level_total, [53:43] level_ii,
    // [64:54] level_ir, [75:65] level_rr, [79:76] zero
    output logic [bcc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] edge_conflict, [1] overflow
    output logic [bcc_pkg::M_TUSER_W-1:0] m_axis_tuser,
    // last_of_run
    output logic                          m_axis_tlast
);

    localparam int ISS_W = $clog2(MAX_EDGES + 1);

    // run sequencer
    localparam logic [1:0] ST_RUN   = 2'd0;  // taking edges
    localparam logic [1:0] ST_DRAIN = 2'd1;  // waiting for the last edge to leave the row
    localparam logic [1:0] ST_EMIT  = 2'd2;  // shifting results out

    logic [1:0] r_state;
    logic [1:0] n_state;

    logic [ISS_W-1:0]            r_issued;   // edges taken this run, saturating
    logic [bcc_pkg::IDX_W-1:0]   r_idx;      // index of the result at the head
    logic [bcc_pkg::LAYER_W-1:0] r_layer;
    logic [bcc_pkg::SUM_W-1:0]   r_sum_all;
    logic [bcc_pkg::SUM_W-1:0]   r_sum_ii;
    logic [bcc_pkg::SUM_W-1:0]   r_sum_ir;
    logic [bcc_pkg::SUM_W-1:0]   r_sum_rr;
    logic                        r_dropped;

    logic w_in_acc;
    logic w_out_acc;
    logic w_run_end;

    bcc_pkg::t_tok w_tok [MAX_EDGES+1];
    bcc_pkg::t_ent w_ent [MAX_EDGES+1];
    bcc_pkg::t_tok w_tail;
    bcc_pkg::t_ent w_head;

    assign s_axis_tready = (r_state == ST_RUN);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;

    // new edge enters cell 0; once the store is full it only passes through
    always_comb begin
        w_tok[0]      = '0;
        w_tok[0].vld  = w_in_acc;
        w_tok[0].drop = (r_issued == ISS_W'(MAX_EDGES));
        w_tok[0].done = (r_issued == ISS_W'(MAX_EDGES));
        w_tok[0].last = s_axis_tlast;
        w_tok[0].src  = bcc_pkg::clamp_pos(s_axis_tdata[15:8]);
        w_tok[0].dst  = bcc_pkg::clamp_pos(s_axis_tdata[23:16]);
        w_tok[0].inn  = s_axis_tuser;
    end

    assign w_ent[MAX_EDGES] = '0;

    for (genvar k = 0; k < MAX_EDGES; k++) begin : g_cell
        bcc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_out_acc),
            .i_tok   (w_tok[k]),
            .i_nxt   (w_ent[k+1]),
            .o_tok   (w_tok[k+1]),
            .o_ent   (w_ent[k])
        );
    end

    assign w_tail = w_tok[MAX_EDGES];
    assign w_head = w_ent[0];

    // run ends on the final result, or at once if nothing was stored
    assign w_run_end = (r_state == ST_EMIT) &&
                       (!w_head.vld || (w_out_acc && !w_ent[1].vld));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (w_in_acc && s_axis_tlast) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_tail.vld && w_tail.last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_run_end) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_issued  <= '0;
            r_idx     <= '0;
            r_sum_all <= '0;
            r_sum_ii  <= '0;
            r_sum_ir  <= '0;
            r_sum_rr  <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_run_end) begin
                r_issued  <= '0;
                r_idx     <= '0;
                r_sum_all <= '0;
                r_sum_ii  <= '0;
                r_sum_ir  <= '0;
                r_sum_rr  <= '0;
                r_dropped <= 1'b0;
            end else begin
                if (w_in_acc && (r_issued != ISS_W'(MAX_EDGES))) begin
                    r_issued <= r_issued + 1'b1;
                end
                if (w_out_acc) begin
                    r_idx <= r_idx + 1'b1;
                end
                // level totals fold in each stored edge's counts as it leaves the row
                if (w_tail.vld) begin
                    if (w_tail.drop) begin
                        r_dropped <= 1'b1;
                    end else begin
                        r_sum_ii  <= r_sum_ii + bcc_pkg::SUM_W'(w_tail.ii);
                        r_sum_ir  <= r_sum_ir + bcc_pkg::SUM_W'(w_tail.ir);
                        r_sum_rr  <= r_sum_rr + bcc_pkg::SUM_W'(w_tail.rr);
                        r_sum_all <= r_sum_all + bcc_pkg::SUM_W'(w_tail.ii)
                                   + bcc_pkg::SUM_W'(w_tail.ir)
                                   + bcc_pkg::SUM_W'(w_tail.rr);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_layer <= s_axis_tdata[7:0];
        end
    end

    assign m_axis_tvalid = (r_state == ST_EMIT) && w_head.vld;
    assign m_axis_tlast  = !w_ent[1].vld;
    assign m_axis_tuser  = {r_dropped, (!w_head.inn && (w_head.ir != '0))};
    assign m_axis_tdata  = {4'b0000, r_sum_rr, r_sum_ir, r_sum_ii, r_sum_all,
                            w_head.rr, w_head.ir, w_head.ii, r_idx, r_layer};

    // no input while results are going out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken during result output");

    // the row is empty of traveling edges once output starts
    a_row_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !w_tail.vld)
        else $error("edge still in flight during output");

    // drops only happen with a full store
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |-> (r_issued == ISS_W'(MAX_EDGES)))
        else $error("overflow with free cells");

    // the final result closes the run and clears the totals
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && m_axis_tlast) |=> (r_state == ST_RUN) && (r_sum_all == '0)
                                        && !w_ent[0].vld)
        else $error("run not cleared after final result");

endmodule
